FILE: hdl/lmfb_pkg.sv
// Shared constants, op codes and pixel helpers for the LED matrix frame buffer.
package lmfb_pkg;

  localparam int PANEL_WIDTH  = 64;
  localparam int PANEL_HEIGHT = 16;
  localparam int ROW_AW       = $clog2(PANEL_HEIGHT);
  localparam int COL_AW       = $clog2(PANEL_WIDTH);
  localparam int MEM_DEPTH    = 2 * PANEL_HEIGHT;
  localparam int MEM_AW       = ROW_AW + 1;
  localparam int CHIP_COLS    = 16;
  localparam int CHIP_ROWS    = 8;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_BLIT  = 2'd1;
  localparam logic [1:0] OP_SCAN  = 2'd2;

  // Byte index of the first column covered by each driver chip.
  function automatic logic [2:0] chip_col_byte(input logic [2:0] chip);
    logic [2:0] b;
    case (chip)
      3'd0, 3'd2: b = 3'd0;
      3'd1, 3'd3: b = 3'd2;
      3'd4, 3'd6: b = 3'd4;
      3'd5, 3'd7: b = 3'd6;
      default:    b = 3'd0;
    endcase
    return b;
  endfunction

  // High when the chip covers the higher eight rows (8 to 15) of the panel.
  function automatic logic chip_row_high(input logic [2:0] chip);
    logic h;
    case (chip)
      3'd2, 3'd3, 3'd6, 3'd7: h = 1'b1;
      default:                h = 1'b0;
    endcase
    return h;
  endfunction

  // Pixels of one image row placed at a signed x and clipped to the panel.
  function automatic logic [PANEL_WIDTH-1:0] blit_mask(input logic signed [7:0] xp,
                                                       input logic [7:0] bits,
                                                       input logic [3:0] w);
    logic [PANEL_WIDTH-1:0] m;
    logic signed [8:0] x;
    int i;
    m = '0;
    for (i = 0; i < 8; i++) begin
      x = $signed({xp[7], xp}) + $signed(9'(i));
      if ((4'(i) < w) && bits[3'(7 - i)] && !x[8] && (x[7:COL_AW] == '0)) begin
        m[x[COL_AW-1:0]] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

FILE: hdl/lmfb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lmfb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/led_matrix_framebuffer_blit_scan.sv
// Top level of the two-plane LED matrix frame buffer with row blit and chip scan.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_stall   op, plane, x_pos, row_y, row_bits, row_width, chip
//   output   out_valid / out_stall nibble, chip_out, plane_out, position, last
//
// A clear is done when it is accepted; a blit reads the row, then writes it back
// with the OR applied. A scan reads the chip's eight rows from the plane memory,
// one memory read per cycle, then sends out 32 nibbles. Reset and clear drop the
// per-row valid bits, so every row reads as zero; there is no clearing pass. Output
// stalls hold the output phase of a scan in place; a new item is taken as soon as
// the last nibble is in the output register.
module led_matrix_framebuffer_blit_scan
  import lmfb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic              plane,
  input  logic signed [7:0] x_pos,
  input  logic signed [5:0] row_y,
  input  logic [7:0]        row_bits,
  input  logic [3:0]        row_width,
  input  logic [2:0]        chip,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        nibble,
  output logic [2:0]        chip_out,
  output logic              plane_out,
  output logic [4:0]        position,
  output logic              last
);

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_BLIT_WR  = 2'd1;
  localparam logic [1:0] ST_SCAN_RD  = 2'd2;
  localparam logic [1:0] ST_SCAN_OUT = 2'd3;

  logic [1:0]             state;
  logic [MEM_DEPTH-1:0]   row_valid;
  logic [MEM_AW-1:0]      blit_addr;
  logic [PANEL_WIDTH-1:0] blit_bits;
  logic                   rd_ok;
  logic                   rd_pend;
  logic [2:0]             rd_idx;
  logic [2:0]             rcnt;
  logic [4:0]             pos;
  logic [2:0]             scan_chip;
  logic                   scan_plane;
  logic [2:0]             scan_byte;
  logic                   scan_yhi;
  logic [CHIP_COLS-1:0]   slice_rows [CHIP_ROWS];

  logic                   accept;
  logic                   blit_ok;
  logic                   emit;
  logic                   ram_re;
  logic                   ram_we;
  logic [MEM_AW-1:0]      ram_raddr;
  logic [PANEL_WIDTH-1:0] ram_rdata;
  logic [PANEL_WIDTH-1:0] rd_word;
  logic [3:0]             nib_next;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign blit_ok  = (op == OP_BLIT) && (row_y[5:ROW_AW] == '0);
  assign ram_we   = (state == ST_BLIT_WR);
  assign rd_word  = rd_ok ? ram_rdata : '0;
  assign emit     = (state == ST_SCAN_OUT) && !rd_pend && (!out_valid || !out_stall);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = {plane, row_y[ROW_AW-1:0]};
    if (accept && blit_ok) begin
      ram_re = 1'b1;
    end else if (state == ST_SCAN_RD) begin
      ram_re    = 1'b1;
      ram_raddr = {scan_plane, scan_yhi, rcnt};
    end
  end

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      nib_next[d] = slice_rows[{pos[0], 2'(d)}][pos[4:1]];
    end
  end

  lmfb_ram #(
    .WIDTH(PANEL_WIDTH),
    .DEPTH(MEM_DEPTH)
  ) u_planes (
    .clk  (clk),
    .we   (ram_we),
    .waddr(blit_addr),
    .wdata(rd_word | blit_bits),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_ok <= row_valid[ram_raddr];
    end
    if (accept) begin
      blit_addr  <= {plane, row_y[ROW_AW-1:0]};
      blit_bits  <= blit_mask(x_pos, row_bits, row_width);
      scan_chip  <= chip;
      scan_plane <= plane;
      scan_byte  <= chip_col_byte(chip);
      scan_yhi   <= chip_row_high(chip);
    end
    rd_idx <= rcnt;
    if (rd_pend) begin
      slice_rows[rd_idx] <= rd_word[{scan_byte, 3'b000} +: CHIP_COLS];
    end
    if (emit) begin
      nibble    <= nib_next;
      chip_out  <= scan_chip;
      plane_out <= scan_plane;
      position  <= pos;
      last      <= (pos == 5'd31);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= '0;
      rd_pend   <= 1'b0;
      rcnt      <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= (state == ST_SCAN_RD);
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (op == OP_CLEAR) begin
              row_valid <= '0;
            end else if (blit_ok) begin
              state <= ST_BLIT_WR;
            end else if (op == OP_SCAN) begin
              state <= ST_SCAN_RD;
              rcnt  <= '0;
              pos   <= '0;
            end
          end
        end
        ST_BLIT_WR: begin
          row_valid[blit_addr] <= 1'b1;
          state                <= ST_IDLE;
        end
        ST_SCAN_RD: begin
          rcnt <= rcnt + 3'd1;
          if (rcnt == 3'd7) begin
            state <= ST_SCAN_OUT;
          end
        end
        ST_SCAN_OUT: begin
          if (emit) begin
            pos <= pos + 5'd1;
            if (pos == 5'd31) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !ram_re)
    else $error("plane memory read and written in the same cycle");

  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> $past(ram_re))
    else $error("blit write-back without a preceding read");

  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_SCAN) |=> (state == ST_SCAN_RD) && (rcnt == 3'd0) && (pos == 5'd0))
    else $error("scan did not start at its first row");

  a_last_position: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (position == 5'd31))
    else $error("last flag on a nibble other than the final one");

  a_emit_after_reads: assert property (@(posedge clk) disable iff (rst)
    emit |-> $past(state) != ST_SCAN_RD)
    else $error("nibble emitted before all chip rows were captured");

endmodule

FILE: tb/sv/lmfb_scan_checker.sv
// Checker for the LED matrix frame buffer: models both planes and compares every scanned nibble.
`timescale 1ns / 1ps

module lmfb_scan_checker
  import lmfb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        op,
  input  logic              plane,
  input  logic signed [7:0] x_pos,
  input  logic signed [5:0] row_y,
  input  logic [7:0]        row_bits,
  input  logic [3:0]        row_width,
  input  logic [2:0]        chip,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [3:0]        nibble,
  input  logic [2:0]        chip_out,
  input  logic              plane_out,
  input  logic [4:0]        position,
  input  logic              last,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [3:0] nibble;
    logic [2:0] chip;
    logic       plane;
    logic [4:0] position;
    logic       last;
  } scan_nibble_t;

  logic [PANEL_WIDTH-1:0] green_rows [PANEL_HEIGHT];
  logic [PANEL_WIDTH-1:0] red_rows [PANEL_HEIGHT];
  scan_nibble_t           nibbles_due [$];
  int                     mismatches = 0;

  function automatic logic [PANEL_WIDTH-1:0] placed_row(input logic signed [7:0] xs,
                                                        input logic [7:0] bits,
                                                        input logic [3:0] w);
    logic [PANEL_WIDTH-1:0] r;
    int k;
    int px;
    r = '0;
    for (k = 0; k < 8; k++) begin
      px = int'(xs) + k;
      if (k < int'(w) && bits[7-k] && px >= 0 && px < PANEL_WIDTH) begin
        r[px] = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0h, actual %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    scan_nibble_t got;
    scan_nibble_t want;
    logic [PANEL_WIDTH-1:0] blit_row;
    int col;
    int half;
    int d;
    int px;
    int py;
    int col_base;
    int row_base;
    if (rst) begin
      for (py = 0; py < PANEL_HEIGHT; py++) begin
        green_rows[py] = '0;
        red_rows[py]   = '0;
      end
      nibbles_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {nibble, chip_out, plane_out, position, last};
        if (nibbles_due.size() == 0) begin
          mismatches++;
          $error("unexpected nibble %0h chip %0d position %0d", nibble, chip_out, position);
        end else begin
          want = nibbles_due.pop_front();
          check_field("nibble", 8'(want.nibble), 8'(got.nibble));
          check_field("chip_out", 8'(want.chip), 8'(got.chip));
          check_field("plane_out", 8'(want.plane), 8'(got.plane));
          check_field("position", 8'(want.position), 8'(got.position));
          check_field("last", 8'(want.last), 8'(got.last));
        end
      end
      if (in_valid && !in_stall) begin
        case (op)
          OP_CLEAR: begin
            for (py = 0; py < PANEL_HEIGHT; py++) begin
              green_rows[py] = '0;
              red_rows[py]   = '0;
            end
          end
          OP_BLIT: begin
            if (row_y >= 0 && row_y < PANEL_HEIGHT) begin
              blit_row = placed_row(x_pos, row_bits, row_width);
              if (plane) begin
                red_rows[row_y[3:0]] = red_rows[row_y[3:0]] | blit_row;
              end else begin
                green_rows[row_y[3:0]] = green_rows[row_y[3:0]] | blit_row;
              end
            end
          end
          OP_SCAN: begin
            col_base = {chip[2], chip[0], 4'b0000};
            row_base = {chip[1], 3'b000};
            for (col = 0; col < 16; col++) begin
              for (half = 0; half < 2; half++) begin
                want = '0;
                px = col_base + col;
                for (d = 0; d < 4; d++) begin
                  py = row_base + half * 4 + d;
                  want.nibble[d] = plane ? red_rows[py][px] : green_rows[py][px];
                end
                want.chip     = chip;
                want.plane    = plane;
                want.position = 5'(col * 2 + half);
                want.last     = (col == 15 && half == 1);
                nibbles_due.push_back(want);
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
    pending    <= nibbles_due.size();
    fail_count <= mismatches;
  end

endmodule

FILE: tb/sv/led_matrix_framebuffer_blit_scan_tb.sv
// Top of the LED matrix frame buffer testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module led_matrix_framebuffer_blit_scan_tb
  import lmfb_pkg::*;
;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        op;
  logic              plane;
  logic signed [7:0] x_pos;
  logic signed [5:0] row_y;
  logic [7:0]        row_bits;
  logic [3:0]        row_width;
  logic [2:0]        chip;
  logic              out_valid;
  logic              out_stall;
  logic [3:0]        nibble;
  logic [2:0]        chip_out;
  logic              plane_out;
  logic [4:0]        position;
  logic              last;
  int                fail_count;
  int                pending;

  logic gaps_on;
  logic stalls_on;
  logic hold_request;

  led_matrix_framebuffer_blit_scan dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .plane(plane), .x_pos(x_pos), .row_y(row_y), .row_bits(row_bits),
    .row_width(row_width), .chip(chip), .out_valid(out_valid), .out_stall(out_stall),
    .nibble(nibble), .chip_out(chip_out), .plane_out(plane_out), .position(position),
    .last(last)
  );

  lmfb_scan_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .plane(plane), .x_pos(x_pos), .row_y(row_y), .row_bits(row_bits),
    .row_width(row_width), .chip(chip), .out_valid(out_valid), .out_stall(out_stall),
    .nibble(nibble), .chip_out(chip_out), .plane_out(plane_out), .position(position),
    .last(last), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("led_matrix_framebuffer_blit_scan test failed");
    $finish;
  end

  // The receiver stalls in random bursts, and once for a long stretch on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic [1:0] o, input logic p, input logic signed [7:0] xs,
                           input logic signed [5:0] ys, input logic [7:0] bits,
                           input logic [3:0] w, input logic [2:0] c);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= o;
    plane     <= p;
    x_pos     <= xs;
    row_y     <= ys;
    row_bits  <= bits;
    row_width <= w;
    chip      <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random;
    int pick;
    logic signed [7:0] xs;
    logic signed [5:0] ys;
    logic [3:0] w;
    pick = $urandom_range(0, 99);
    xs   = 8'($urandom);
    ys   = 6'($urandom);
    w    = 4'($urandom);
    if (pick < 3) begin
      send_item(OP_CLEAR, 1'($urandom), xs, ys, 8'($urandom), w, 3'($urandom));
    end else if (pick < 55) begin
      xs = 8'($urandom_range(0, 71) - 8);
      ys = 6'($urandom_range(0, PANEL_HEIGHT - 1));
      w  = 4'($urandom_range(0, 8));
      send_item(OP_BLIT, 1'($urandom), xs, ys, 8'($urandom), w, 3'($urandom));
    end else if (pick < 88) begin
      send_item(OP_SCAN, 1'($urandom), xs, ys, 8'($urandom), w, 3'($urandom));
    end else if (pick < 94) begin
      send_item(OP_BLIT, 1'($urandom), xs, ys, 8'($urandom), w, 3'($urandom));
    end else begin
      send_item(OP_UNUSED, 1'($urandom), xs, ys, 8'($urandom), w, 3'($urandom));
    end
  endtask

  initial begin
    int n;
    rst          = 1'b1;
    in_valid     = 1'b0;
    out_stall    = 1'b0;
    op           = OP_CLEAR;
    plane        = 1'b0;
    x_pos        = '0;
    row_y        = '0;
    row_bits     = '0;
    row_width    = '0;
    chip         = '0;
    gaps_on      = 1'b0;
    stalls_on    = 1'b0;
    hold_request = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(OP_SCAN, 1'b0, 8'sd0, 6'sd0, 8'h00, 4'd0, 3'd0);
    send_item(OP_BLIT, 1'b0, 8'sd0, 6'sd0, 8'hFF, 4'd8, 3'd0);
    send_item(OP_BLIT, 1'b1, -8'sd128, -6'sd32, 8'hFF, 4'd15, 3'd7);
    send_item(OP_BLIT, 1'b1, 8'sd127, 6'sd31, 8'hFF, 4'd8, 3'd0);
    send_item(OP_BLIT, 1'b1, -8'sd3, 6'sd15, 8'hFF, 4'd8, 3'd0);
    send_item(OP_BLIT, 1'b0, 8'sd60, 6'sd7, 8'hAA, 4'd8, 3'd0);
    send_item(OP_BLIT, 1'b0, 8'sd20, 6'sd3, 8'hFF, 4'd0, 3'd0);
    send_item(OP_BLIT, 1'b1, 8'sd56, 6'sd8, 8'h55, 4'd9, 3'd0);
    send_item(OP_BLIT, 1'b0, 8'sd40, 6'sd12, 8'hC3, 4'd15, 3'd0);
    send_item(OP_UNUSED, 1'b1, 8'sd5, 6'sd5, 8'hFF, 4'd8, 3'd1);
    for (n = 0; n < 8; n++) begin
      send_item(OP_SCAN, 1'(n), 8'sd0, 6'sd0, 8'h00, 4'd0, 3'(n));
    end
    send_item(OP_CLEAR, 1'b0, 8'sd0, 6'sd0, 8'h00, 4'd0, 3'd0);
    send_item(OP_SCAN, 1'b1, 8'sd0, 6'sd0, 8'h00, 4'd0, 3'd7);
    send_item(OP_SCAN, 1'b0, 8'sd0, 6'sd0, 8'h00, 4'd0, 3'd0);
    wait_drained();

    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    for (n = 0; n < 100; n++) send_random();

    hold_request = 1'b1;
    for (n = 0; n < 24; n++) begin
      send_item(OP_SCAN, 1'($urandom), 8'sd0, 6'sd0, 8'($urandom), 4'($urandom), 3'($urandom));
    end
    wait_drained();

    for (n = 0; n < 100; n++) send_random();

    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (n = 0; n < 30; n++) send_random();
    in_valid <= 1'b0;

    wait_drained();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("led_matrix_framebuffer_blit_scan test passed");
    end else begin
      $display("led_matrix_framebuffer_blit_scan test failed");
    end
    $finish;
  end

endmodule
